FILE: sv/mer_pkg.sv
// ---------------------------------------------------------------------------
// mer_pkg - shared types and constants
// Field widths, multiplier operand codes and the command and status
// structs that join the controller to the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

    localparam int RADIUS_IN_W = 10;  // width of the radius ports
    localparam int CENTER_W    = 11;
    localparam int COORD_W     = 12;
    localparam int OFFX_W      = 11;
    localparam int OFFY_W      = 12;
    localparam int SLOPE_W     = 34;
    localparam int DEC_W       = 48;
    localparam int SQ_W        = 20;
    localparam int TMP_W       = 24;  // holds (2x+1)^2 and (y-1)^2
    localparam int MUL_W       = 25;
    localparam int PROD_W      = 2 * MUL_W;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_RX2_RY,
        MUL_TX_TX,
        MUL_TY_TY,
        MUL_RY2_T,
        MUL_RX2_T,
        MUL_RX2_RY2
    } mul_op_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_RX2,
        ACC_RY2,
        ACC_START,
        ACC_T,
        ACC_DEC_LOAD,
        ACC_DEC_ADD4,
        ACC_DEC_SUB4
    } acc_op_t;

    typedef struct packed {
        mul_op_t mul_op;
        acc_op_t acc_op;
        logic    latch_start;
        logic    load_out;
        logic    dec_step;
        logic    region_two;
    } mer_cmd_t;

    typedef struct packed {
        logic need_switch;
        logic out_free;
        logic last_point;
    } mer_stat_t;

endpackage

`default_nettype wire

FILE: sv/mer_mult.sv
// ---------------------------------------------------------------------------
// mer_mult - shared signed multiplier
// One signed product per cycle, registered at the output.
// ---------------------------------------------------------------------------
`default_nettype none

module mer_mult (
    input  wire logic                               aclk,
    input  wire logic signed [mer_pkg::MUL_W-1:0]   op_a,
    input  wire logic signed [mer_pkg::MUL_W-1:0]   op_b,
    output logic signed      [mer_pkg::PROD_W-1:0]  prod
);
    import mer_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: sv/mer_datapath.sv
// ---------------------------------------------------------------------------
// mer_datapath - ellipse walk datapath
// Holds center, radii, offsets, slope terms and the decision value,
// drives the shared multiplier and owns the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mer_datapath #(
    parameter int RADIUS_BITS = 10
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire mer_pkg::mer_cmd_t                   cmd,
    output mer_pkg::mer_stat_t                       stat,
    input  wire logic signed [mer_pkg::CENTER_W-1:0] s_center_x,
    input  wire logic signed [mer_pkg::CENTER_W-1:0] s_center_y,
    input  wire logic [mer_pkg::RADIUS_IN_W-1:0]     s_radius_x,
    input  wire logic [mer_pkg::RADIUS_IN_W-1:0]     s_radius_y,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [mer_pkg::COORD_W-1:0]       m_right_x,
    output logic signed [mer_pkg::COORD_W-1:0]       m_left_x,
    output logic signed [mer_pkg::COORD_W-1:0]       m_top_y,
    output logic signed [mer_pkg::COORD_W-1:0]       m_bottom_y,
    output logic                                     m_last_set
);
    import mer_pkg::*;

    localparam int RB = (RADIUS_BITS < RADIUS_IN_W) ? RADIUS_BITS : RADIUS_IN_W;

    logic signed [CENTER_W-1:0] cx_reg, cy_reg;
    logic [RB-1:0]              rx_reg, ry_reg;
    logic [SQ_W-1:0]            rx2_reg, ry2_reg;
    logic [TMP_W-1:0]           t_reg;
    logic [OFFX_W-1:0]          ox_reg;
    logic signed [OFFY_W-1:0]   oy_reg;
    logic signed [SLOPE_W-1:0]  sx_reg, sy_reg;
    logic signed [DEC_W-1:0]    dec_reg;
    logic                       br_reg;

    logic                       out_valid_reg;
    logic signed [COORD_W-1:0]  right_reg, left_reg, top_reg, bottom_reg;
    logic                       last_reg;

    logic signed [MUL_W-1:0]    op_a, op_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [OFFY_W-1:0]   ty;
    logic signed [DEC_W-1:0]    sx_e, sy_e, rx2_e, ry2_e, term, prod4;
    logic [SLOPE_W-1:0]         two_rx2, two_ry2;
    logic signed [COORD_W-1:0]  cx_e, cy_e, ox_e;
    logic                       dec_neg, dec_pos;

    mer_mult u_mult (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign ty = oy_reg - OFFY_W'(1);

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.mul_op)
            MUL_NONE:    begin op_a = '0;               op_b = '0;               end
            MUL_RX_RX:   begin op_a = MUL_W'(rx_reg);   op_b = MUL_W'(rx_reg);   end
            MUL_RY_RY:   begin op_a = MUL_W'(ry_reg);   op_b = MUL_W'(ry_reg);   end
            MUL_RX2_RY:  begin op_a = MUL_W'(rx2_reg);  op_b = MUL_W'(ry_reg);   end
            MUL_TX_TX:   begin
                op_a = MUL_W'({ox_reg, 1'b1});
                op_b = MUL_W'({ox_reg, 1'b1});
            end
            MUL_TY_TY:   begin op_a = MUL_W'(ty);       op_b = MUL_W'(ty);       end
            MUL_RY2_T:   begin op_a = MUL_W'(ry2_reg);  op_b = MUL_W'(t_reg);    end
            MUL_RX2_T:   begin op_a = MUL_W'(rx2_reg);  op_b = MUL_W'(t_reg);    end
            MUL_RX2_RY2: begin op_a = MUL_W'(rx2_reg);  op_b = MUL_W'(ry2_reg);  end
            default:     begin op_a = '0;               op_b = '0;               end
        endcase
    end

    assign sx_e    = DEC_W'(sx_reg);
    assign sy_e    = DEC_W'(sy_reg);
    assign rx2_e   = DEC_W'(rx2_reg);
    assign ry2_e   = DEC_W'(ry2_reg);
    assign prod4   = {prod[DEC_W-3:0], 2'b00};
    assign two_rx2 = SLOPE_W'({rx2_reg, 1'b0});
    assign two_ry2 = SLOPE_W'({ry2_reg, 1'b0});
    assign dec_neg = dec_reg[DEC_W-1];
    assign dec_pos = !dec_reg[DEC_W-1] && (dec_reg != '0);

    // decision increment, from the slope terms already advanced
    always_comb begin
        if (!cmd.region_two && br_reg) begin
            term = sx_e + ry2_e;
        end else if (cmd.region_two && br_reg) begin
            term = rx2_e - sy_e;
        end else begin
            term = sx_e - sy_e + (cmd.region_two ? rx2_e : ry2_e);
        end
    end

    assign cx_e = COORD_W'(cx_reg);
    assign cy_e = COORD_W'(cy_reg);
    assign ox_e = COORD_W'(ox_reg);

    always_ff @(posedge aclk) begin
        if (cmd.latch_start) begin
            cx_reg <= s_center_x;
            cy_reg <= s_center_y;
            rx_reg <= s_radius_x[RB-1:0];
            ry_reg <= s_radius_y[RB-1:0];
        end

        unique case (cmd.acc_op)
            ACC_NONE: begin
            end
            ACC_RX2: begin
                rx2_reg <= prod[SQ_W-1:0];
            end
            ACC_RY2: begin
                ry2_reg <= prod[SQ_W-1:0];
            end
            ACC_START: begin
                ox_reg  <= '0;
                oy_reg  <= OFFY_W'(ry_reg);
                sx_reg  <= '0;
                sy_reg  <= {prod[SLOPE_W-2:0], 1'b0};
                dec_reg <= {ry2_e[DEC_W-3:0], 2'b00} + rx2_e - prod4;
            end
            ACC_T: begin
                t_reg <= prod[TMP_W-1:0];
            end
            ACC_DEC_LOAD: begin
                dec_reg <= prod[DEC_W-1:0];
            end
            ACC_DEC_ADD4: begin
                dec_reg <= dec_reg + prod4;
            end
            ACC_DEC_SUB4: begin
                dec_reg <= dec_reg - prod4;
            end
            default: begin
            end
        endcase

        if (cmd.load_out) begin
            right_reg  <= cx_e + ox_e;
            left_reg   <= cx_e - ox_e;
            top_reg    <= cy_e + oy_reg;
            bottom_reg <= cy_e - oy_reg;
            last_reg   <= cmd.region_two && (oy_reg == '0);
            if (!cmd.region_two) begin
                ox_reg <= ox_reg + OFFX_W'(1);
                sx_reg <= sx_reg + two_ry2;
                br_reg <= dec_neg;
                if (!dec_neg) begin
                    oy_reg <= oy_reg - OFFY_W'(1);
                    sy_reg <= sy_reg - two_rx2;
                end
            end else begin
                oy_reg <= oy_reg - OFFY_W'(1);
                sy_reg <= sy_reg - two_rx2;
                br_reg <= dec_pos;
                if (!dec_pos) begin
                    ox_reg <= ox_reg + OFFX_W'(1);
                    sx_reg <= sx_reg + two_ry2;
                end
            end
        end

        if (cmd.dec_step) begin
            dec_reg <= dec_reg + {term[DEC_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.need_switch = (sx_reg >= sy_reg);
    assign stat.out_free    = !out_valid_reg || m_ready;
    assign stat.last_point  = (oy_reg == '0);

    assign m_valid    = out_valid_reg;
    assign m_right_x  = right_reg;
    assign m_left_x   = left_reg;
    assign m_top_y    = top_reg;
    assign m_bottom_y = bottom_reg;
    assign m_last_set = last_reg;

endmodule

`default_nettype wire

FILE: sv/mer_ctrl.sv
// ---------------------------------------------------------------------------
// mer_ctrl - ellipse walk controller
// Accepts items, sequences the multiplier for set-up and the region
// switch, and paces each point-set step.
// ---------------------------------------------------------------------------
`default_nettype none

module mer_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_kind,
    input  wire mer_pkg::mer_stat_t   stat,
    output mer_pkg::mer_cmd_t         cmd
);
    import mer_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_1,
        ST_START_2,
        ST_START_3,
        ST_START_4,
        ST_SW_1,
        ST_SW_2,
        ST_SW_3,
        ST_SW_4,
        ST_SW_5,
        ST_SW_6,
        ST_STEP_A,
        ST_STEP_B
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   r2_reg, r2_next;

    always_comb begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        r2_next         = r2_reg;
        cmd.mul_op      = MUL_NONE;
        cmd.acc_op      = ACC_NONE;
        cmd.latch_start = 1'b0;
        cmd.load_out    = 1'b0;
        cmd.dec_step    = 1'b0;
        cmd.region_two  = r2_reg;
        s_ready         = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_kind) begin
                        // drop any walk in progress
                        cmd.latch_start = 1'b1;
                        busy_next       = 1'b0;
                        state_next      = ST_START_1;
                    end else if (busy_reg) begin
                        state_next = (!r2_reg && stat.need_switch) ? ST_SW_1 : ST_STEP_A;
                    end
                end
            end
            ST_START_1: begin
                cmd.mul_op = MUL_RX_RX;
                state_next = ST_START_2;
            end
            ST_START_2: begin
                cmd.acc_op = ACC_RX2;
                cmd.mul_op = MUL_RY_RY;
                state_next = ST_START_3;
            end
            ST_START_3: begin
                cmd.acc_op = ACC_RY2;
                cmd.mul_op = MUL_RX2_RY;
                state_next = ST_START_4;
            end
            ST_START_4: begin
                cmd.acc_op = ACC_START;
                busy_next  = 1'b1;
                r2_next    = 1'b0;
                state_next = ST_IDLE;
            end
            ST_SW_1: begin
                cmd.mul_op = MUL_TX_TX;
                state_next = ST_SW_2;
            end
            ST_SW_2: begin
                cmd.acc_op = ACC_T;
                cmd.mul_op = MUL_TY_TY;
                state_next = ST_SW_3;
            end
            ST_SW_3: begin
                cmd.acc_op = ACC_T;
                cmd.mul_op = MUL_RY2_T;
                state_next = ST_SW_4;
            end
            ST_SW_4: begin
                cmd.acc_op = ACC_DEC_LOAD;
                cmd.mul_op = MUL_RX2_T;
                state_next = ST_SW_5;
            end
            ST_SW_5: begin
                cmd.acc_op = ACC_DEC_ADD4;
                cmd.mul_op = MUL_RX2_RY2;
                state_next = ST_SW_6;
            end
            ST_SW_6: begin
                cmd.acc_op = ACC_DEC_SUB4;
                r2_next    = 1'b1;
                state_next = ST_STEP_A;
            end
            ST_STEP_A: begin
                // hold until the result register can take the transfer
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    if (r2_reg && stat.last_point) begin
                        busy_next = 1'b0;
                    end
                    state_next = ST_STEP_B;
                end
            end
            ST_STEP_B: begin
                cmd.dec_step = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            r2_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            r2_reg    <= r2_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/midpoint_ellipse_rasterizer.sv
// ---------------------------------------------------------------------------
// midpoint_ellipse_rasterizer - two-region midpoint ellipse walk
// A start item loads center and radii; each step item returns the four
// symmetric points of the current position and advances the walk.
//
//   channel | ports                                   | transfer when
//   --------+-----------------------------------------+------------------
//   input   | s_kind s_center_x/y s_radius_x/y        | s_valid & s_ready
//   result  | m_right_x m_left_x m_top_y m_bottom_y   | m_valid & m_ready
//           | m_last_set                              |
//
// Start: three passes of the shared multiplier (START_1 to START_4), then
// the next item is accepted. Step: STEP_A then STEP_B, after SW_1 to SW_6
// on the step that enters region 2, where the multiplier rebuilds the
// decision value in five products. A step while no walk runs gives no result.
// The result register frees the walk from the output side; a step stalls
// only when the previous result has not yet been taken.
// Reset is synchronous; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module midpoint_ellipse_rasterizer #(
    parameter int RADIUS_BITS = 10
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_kind,
    input  wire logic signed [mer_pkg::CENTER_W-1:0] s_center_x,
    input  wire logic signed [mer_pkg::CENTER_W-1:0] s_center_y,
    input  wire logic [mer_pkg::RADIUS_IN_W-1:0]     s_radius_x,
    input  wire logic [mer_pkg::RADIUS_IN_W-1:0]     s_radius_y,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [mer_pkg::COORD_W-1:0]       m_right_x,
    output logic signed [mer_pkg::COORD_W-1:0]       m_left_x,
    output logic signed [mer_pkg::COORD_W-1:0]       m_top_y,
    output logic signed [mer_pkg::COORD_W-1:0]       m_bottom_y,
    output logic                                     m_last_set
);
    import mer_pkg::*;

    mer_cmd_t  cmd;
    mer_stat_t stat;

    mer_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .stat    (stat),
        .cmd     (cmd)
    );

    mer_datapath #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_radius_x (s_radius_x),
        .s_radius_y (s_radius_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_right_x  (m_right_x),
        .m_left_x   (m_left_x),
        .m_top_y    (m_top_y),
        .m_bottom_y (m_bottom_y),
        .m_last_set (m_last_set)
    );

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free)
        else $error("result register loaded while a result waits");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("loaded result not presented");

    // the multiplier only runs while an item is in flight
    a_mult_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mul_op != MUL_NONE) |-> !s_ready)
        else $error("multiplier active while accepting items");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench - midpoint_ellipse_rasterizer
// A short table of directed items (radius and centre extremes, zero radii,
// steps while idle, restarts mid-walk) is followed by random ellipse walks,
// mostly small radii, a few full range and some cut short by a restart.
// Every result transfer is checked field by field against a behavioural
// copy of the two-region walk.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import mer_pkg::*;

    localparam bit KIND_START   = 1'b0;
    localparam bit KIND_STEP    = 1'b1;
    localparam int ITEM_TARGET  = 1400;
    localparam int QUIET_ITEMS  = 150;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] top_y;
        logic signed [COORD_W-1:0] bottom_y;
        logic                      last_set;
    } point_set_t;

    typedef struct packed {
        logic                       kind;
        logic signed [CENTER_W-1:0] center_x;
        logic signed [CENTER_W-1:0] center_y;
        logic [RADIUS_IN_W-1:0]     radius_x;
        logic [RADIUS_IN_W-1:0]     radius_y;
        logic                       fixed_result;
        point_set_t                 result;
    } ellipse_item_t;

    localparam point_set_t NO_POINT = '0;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_kind;
    logic signed [CENTER_W-1:0]  s_center_x;
    logic signed [CENTER_W-1:0]  s_center_y;
    logic [RADIUS_IN_W-1:0]      s_radius_x;
    logic [RADIUS_IN_W-1:0]      s_radius_y;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [COORD_W-1:0]   m_right_x;
    logic signed [COORD_W-1:0]   m_left_x;
    logic signed [COORD_W-1:0]   m_top_y;
    logic signed [COORD_W-1:0]   m_bottom_y;
    logic                        m_last_set;

    always #1 aclk = ~aclk;

    midpoint_ellipse_rasterizer dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_radius_x (s_radius_x),
        .s_radius_y (s_radius_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_right_x  (m_right_x),
        .m_left_x   (m_left_x),
        .m_top_y    (m_top_y),
        .m_bottom_y (m_bottom_y),
        .m_last_set (m_last_set)
    );

    // walk state, decision values scaled by 4
    bit     walking;
    bit     region_two;
    longint off_x, off_y;
    longint slope_x, slope_y;
    longint decision;
    longint rx_sq, ry_sq;
    longint ctr_x, ctr_y;

    point_set_t expected_points[$];

    int  mismatches;
    int  items_fed;
    int  ellipses_started;
    int  walks_cut;
    int  points_checked;
    int  final_sets;
    int  cycles;
    bit  no_idle;

    function automatic bit rasterize_step(input ellipse_item_t item, output point_set_t pt);
        longint rx, ry, tx, ty;
        pt = NO_POINT;
        if (item.kind == KIND_START) begin
            rx = longint'(item.radius_x);
            ry = longint'(item.radius_y);
            ctr_x = longint'(item.center_x);
            ctr_y = longint'(item.center_y);
            rx_sq = rx * rx;
            ry_sq = ry * ry;
            off_x = 0;
            off_y = ry;
            slope_x = 0;
            slope_y = 2 * rx_sq * ry;
            decision = 4 * ry_sq - 4 * rx_sq * ry + rx_sq;
            region_two = 1'b0;
            walking = 1'b1;
            return 1'b0;
        end
        if (!walking)
            return 1'b0;

        if (!region_two && !(slope_x < slope_y)) begin
            tx = 2 * off_x + 1;
            ty = off_y - 1;
            decision = ry_sq * tx * tx + 4 * rx_sq * ty * ty - 4 * rx_sq * ry_sq;
            region_two = 1'b1;
        end

        pt.right_x  = COORD_W'(ctr_x + off_x);
        pt.left_x   = COORD_W'(ctr_x - off_x);
        pt.top_y    = COORD_W'(ctr_y + off_y);
        pt.bottom_y = COORD_W'(ctr_y - off_y);
        pt.last_set = region_two && off_y == 0;

        if (!region_two) begin
            off_x++;
            slope_x += 2 * ry_sq;
            if (decision < 0) begin
                decision += 4 * (slope_x + ry_sq);
            end else begin
                off_y--;
                slope_y -= 2 * rx_sq;
                decision += 4 * (slope_x - slope_y + ry_sq);
            end
        end else begin
            off_y--;
            slope_y -= 2 * rx_sq;
            if (decision > 0) begin
                decision += 4 * (rx_sq - slope_y);
            end else begin
                off_x++;
                slope_x += 2 * ry_sq;
                decision += 4 * (slope_x - slope_y + rx_sq);
            end
            if (off_y < 0)
                walking = 1'b0;
        end
        return 1'b1;
    endfunction

    // offer one item, hold it until the transfer, then predict its result
    task automatic transfer_item(input ellipse_item_t item);
        point_set_t pt;
        bit         ignored;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= item.kind;
        s_center_x <= item.center_x;
        s_center_y <= item.center_y;
        s_radius_x <= item.radius_x;
        s_radius_y <= item.radius_y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);

        ignored = item.kind == KIND_STEP && !walking;
        if (item.kind == KIND_START) begin
            ellipses_started++;
            if (walking)
                walks_cut++;
        end
        if (rasterize_step(item, pt))
            expected_points.push_back(item.fixed_result ? item.result : pt);
        if (!ignored)
            items_fed++;
        if (items_fed >= ITEM_TARGET - QUIET_ITEMS)
            no_idle = 1'b1;
    endtask

    function automatic ellipse_item_t random_item(input bit kind);
        ellipse_item_t item;
        item.kind         = kind;
        item.center_x     = CENTER_W'($urandom);
        item.center_y     = CENTER_W'($urandom);
        item.radius_x     = RADIUS_IN_W'($urandom);
        item.radius_y     = RADIUS_IN_W'($urandom);
        item.fixed_result = 1'b0;
        item.result       = NO_POINT;
        return item;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // result side: check every transfer, stall in random bursts
    initial begin
        int         stall_left;
        point_set_t exp_pt;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    $error("result transfer with no point set expected");
                    mismatches++;
                end else begin
                    exp_pt = expected_points.pop_front();
                    check_field("right_x", int'(exp_pt.right_x), int'(m_right_x));
                    check_field("left_x", int'(exp_pt.left_x), int'(m_left_x));
                    check_field("top_y", int'(exp_pt.top_y), int'(m_top_y));
                    check_field("bottom_y", int'(exp_pt.bottom_y), int'(m_bottom_y));
                    check_field("last_set", int'(exp_pt.last_set), int'(m_last_set));
                    points_checked++;
                    if (exp_pt.last_set)
                        final_sets++;
                end
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[midpoint_ellipse_rasterizer] ERROR");
            $finish;
        end
    end

    initial begin
        ellipse_item_t directed_items [25];
        ellipse_item_t item;
        int            pick, cap, steps, extra;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_kind     = KIND_START;
        s_center_x = '0;
        s_center_y = '0;
        s_radius_x = '0;
        s_radius_y = '0;
        walking    = 1'b0;
        region_two = 1'b0;

        directed_items = '{
            // step straight after reset: ignored
            '{KIND_STEP,  11'sd1023,  -11'sd1024, 10'd1023, 10'd0,    1'b0, NO_POINT},
            // zero radii: a single set at the centre, flagged last
            '{KIND_START, 11'sd0,     11'sd0,     10'd0,    10'd0,    1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b1,
              '{12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b1}},
            '{KIND_STEP,  -11'sd1,    11'sd1,     10'd1023, 10'd1023, 1'b0, NO_POINT},
            '{KIND_START, 11'sd1023,  -11'sd1024, 10'd0,    10'd0,    1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b1,
              '{12'sd1023, 12'sd1023, -12'sd1024, -12'sd1024, 1'b1}},
            // widest radii at the corner centre, then cut short
            '{KIND_START, -11'sd1024, 11'sd1023,  10'd1023, 10'd1023, 1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b1,
              '{-12'sd1024, -12'sd1024, 12'sd2046, 12'sd0, 1'b0}},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b0, NO_POINT},
            // flat ellipse: region 2 at once with y already zero
            '{KIND_START, 11'sd1023,  11'sd1023,  10'd1023, 10'd0,    1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b1,
              '{12'sd1023, 12'sd1023, 12'sd1023, 12'sd1023, 1'b1}},
            // zero horizontal radius: region 2 from the first set
            '{KIND_START, -11'sd1024, -11'sd1024, 10'd0,    10'd1023, 1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b1,
              '{-12'sd1024, -12'sd1024, -12'sd1, -12'sd2047, 1'b0}},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b0, NO_POINT},
            '{KIND_START, 11'sd5,     -11'sd7,    10'd341,  10'd682,  1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b0, NO_POINT},
            // unit circle runs to completion; trailing steps are ignored
            '{KIND_START, 11'sd0,     11'sd0,     10'd1,    10'd1,    1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b0, NO_POINT},
            '{KIND_STEP,  11'sd0,     11'sd0,     10'd0,    10'd0,    1'b0, NO_POINT}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_items[i])
            transfer_item(directed_items[i]);

        while (items_fed < ITEM_TARGET) begin
            item = random_item(KIND_START);
            pick = $urandom_range(0, 99);
            cap  = ITEM_TARGET;
            if (pick < 75) begin
                item.radius_x = RADIUS_IN_W'($urandom_range(0, 15));
                item.radius_y = RADIUS_IN_W'($urandom_range(0, 15));
            end else if (pick < 93) begin
                item.radius_x = RADIUS_IN_W'($urandom_range(0, 80));
                item.radius_y = RADIUS_IN_W'($urandom_range(16, 80));
            end else begin
                cap = $urandom_range(20, 250);
            end
            // now and then abandon the walk early with a fresh start
            if ($urandom_range(0, 9) == 0)
                cap = $urandom_range(0, 8);
            transfer_item(item);
            steps = 0;
            while (walking && steps < cap) begin
                transfer_item(random_item(KIND_STEP));
                steps++;
            end
            if (!walking && $urandom_range(0, 6) == 0) begin
                extra = $urandom_range(1, 3);
                repeat (extra) transfer_item(random_item(KIND_STEP));
            end
        end
        s_valid <= 1'b0;

        while (expected_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d items fed over %0d ellipses (%0d restarted mid-walk)",
                 items_fed, ellipses_started, walks_cut);
        $display("%0d point sets checked, %0d of them final", points_checked, final_sets);
        if (mismatches == 0) begin
            $display("[midpoint_ellipse_rasterizer] OK");
        end else begin
            $display("[midpoint_ellipse_rasterizer] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
